// ----- design/sfcp_pkg.sv -----
package sfcp_pkg;

  // Frame layout.
  localparam logic [7:0] Hdr0Byte   = 8'h42;
  localparam logic [7:0] Hdr1Byte   = 8'h52;
  localparam logic [3:0] PosFirst   = 4'd0;
  localparam logic [3:0] PosHdr1    = 4'd1;
  localparam logic [3:0] PosDistLo  = 4'd8;
  localparam logic [3:0] PosDistHi  = 4'd11;
  localparam logic [3:0] PosSumLow  = 4'd13;
  localparam logic [3:0] PosLast    = 4'd14;
  localparam logic [3:0] PosIdle    = 4'd15;

  // Result status codes.
  localparam logic [1:0] StatusOk        = 2'd0;
  localparam logic [1:0] StatusBadHeader = 2'd1;
  localparam logic [1:0] StatusBadSum    = 2'd2;
  localparam logic [1:0] StatusUnused    = 2'd3;

  // One received byte of a reply frame.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  // One frame result.
  typedef struct packed {
    logic [1:0]  frame_status;
    logic [31:0] distance;
  } out_item_t;

endpackage

// ----- design/sonar_frame_checksum_parser_core.sv -----
// Channel   Direction  Handshake            Payload
// in        input      in_valid_i/in_stall_o    sfcp_pkg::in_item_t
// out       output     out_valid_o/out_stall_i  sfcp_pkg::out_item_t
//
// One byte is accepted per cycle unless the input stalls; the result of a
// frame appears on the cycle after its last byte (byte 14) is accepted.
// Each byte passes through one add and a few compares into the frame state.
// Reset returns the parser to idle with the kept distance at zero.
// The input stalls only when a result is still held by a stalled output and
// the next byte could be the last byte of a frame.
module sonar_frame_checksum_parser_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sfcp_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sfcp_pkg::out_item_t  out_data_o
);

  logic [3:0]          pos_q, pos_d;
  logic [15:0]         sum_q, sum_d;
  logic                hdr_good_q, hdr_good_d;
  logic [31:0]         pend_dist_q, pend_dist_d;
  logic                sum_low_q, sum_low_d;
  logic [31:0]         kept_dist_q, kept_dist_d;
  logic                out_valid_q, out_valid_d;
  sfcp_pkg::out_item_t out_data_q, out_data_d;

  logic       in_accept;
  logic [3:0] cur_pos;
  logic [7:0] b;
  logic       high_match;

  // Hold off input only when a last byte could meet a full, stalled output.
  assign in_stall_o = out_valid_q & out_stall_i & (pos_q == sfcp_pkg::PosLast);
  assign in_accept  = in_valid_i & ~in_stall_o;

  assign b          = in_data_i.rx_byte;
  assign cur_pos    = in_data_i.frame_start ? sfcp_pkg::PosFirst : pos_q;
  assign high_match = (sum_q[15:8] == b);

  // Frame state update for one accepted byte.
  always_comb begin
    pos_d       = pos_q;
    sum_d       = sum_q;
    hdr_good_d  = hdr_good_q;
    pend_dist_d = pend_dist_q;
    sum_low_d   = sum_low_q;
    kept_dist_d = kept_dist_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_data_d  = out_data_q;
    if (in_accept && cur_pos != sfcp_pkg::PosIdle) begin
      pos_d = cur_pos + 4'd1;
      if (cur_pos == sfcp_pkg::PosFirst) begin
        sum_d       = {8'd0, b};
        pend_dist_d = '0;
        sum_low_d   = 1'b0;
        hdr_good_d  = (b == sfcp_pkg::Hdr0Byte);
      end else if (cur_pos < sfcp_pkg::PosSumLow) begin
        sum_d = sum_q + {8'd0, b};
      end
      if (cur_pos == sfcp_pkg::PosHdr1) begin
        hdr_good_d = hdr_good_q & (b == sfcp_pkg::Hdr1Byte);
      end
      if (cur_pos >= sfcp_pkg::PosDistLo && cur_pos <= sfcp_pkg::PosDistHi) begin
        pend_dist_d[{cur_pos[1:0], 3'b000} +: 8] = b;
      end
      if (cur_pos == sfcp_pkg::PosSumLow) begin
        sum_low_d = (sum_q[7:0] == b);
      end
      if (cur_pos == sfcp_pkg::PosLast) begin
        pos_d       = sfcp_pkg::PosIdle;
        out_valid_d = 1'b1;
        priority if (!hdr_good_q) begin
          out_data_d.frame_status = sfcp_pkg::StatusBadHeader;
        end else if (!(sum_low_q && high_match)) begin
          out_data_d.frame_status = sfcp_pkg::StatusBadSum;
        end else begin
          out_data_d.frame_status = sfcp_pkg::StatusOk;
          kept_dist_d             = pend_dist_q;
        end
        out_data_d.distance = (hdr_good_q && sum_low_q && high_match) ?
                              pend_dist_q : kept_dist_q;
      end
    end
  end

  // Control and frame state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= sfcp_pkg::PosIdle;
      sum_q       <= '0;
      hdr_good_q  <= 1'b0;
      pend_dist_q <= '0;
      sum_low_q   <= 1'b0;
      kept_dist_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      hdr_good_q  <= hdr_good_d;
      pend_dist_q <= pend_dist_d;
      sum_low_q   <= sum_low_d;
      kept_dist_q <= kept_dist_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- design/sfcp_checker.sv -----
module sfcp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input sfcp_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sfcp_pkg::out_item_t out_data_o
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // The status code never takes the unused value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.frame_status != sfcp_pkg::StatusUnused)
    else $error("unused status code");

  // Once reset has been seen at an edge, no result is shown on the next one.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result during reset");

  // A new result follows an accepted item on the cycle before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("result without an accepted item");

  // The input stalls only behind a stalled, held result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without cause");

endmodule

bind sonar_frame_checksum_parser_core sfcp_checker u_sfcp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- tb/sonar_frame_checksum_parser_core_test.sv -----
`timescale 1ns / 1ps

module sonar_frame_checksum_parser_core_test;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned FrameLen   = 15;

  typedef logic [14:0][7:0] frame_bytes_t;

  typedef enum logic [2:0] {
    KindGood,
    KindBadHdr0,
    KindBadHdr1,
    KindBadSumLow,
    KindBadSumHigh,
    KindBadBoth
  } frame_kind_e;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 out_stall_i = 1'b0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  sfcp_pkg::in_item_t   in_data_i   = '0;
  sfcp_pkg::out_item_t  out_data_o;

  // Parser state as the frames are seen from outside.
  logic [3:0]  trk_pos       = sfcp_pkg::PosIdle;
  logic [15:0] trk_sum       = '0;
  logic        trk_hdr_ok    = 1'b0;
  logic [31:0] trk_dist      = '0;
  logic        trk_low_ok    = 1'b0;
  logic [31:0] last_good_dist = '0;

  sfcp_pkg::out_item_t frame_results_due[$];

  bit          no_idle       = 1'b0;
  int unsigned cycle_count   = 0;
  int unsigned mismatches    = 0;
  int unsigned frame_bytes   = 0;
  int unsigned n_ok          = 0;
  int unsigned n_bad_hdr     = 0;
  int unsigned n_bad_sum     = 0;

  sonar_frame_checksum_parser_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Run guard.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timed out with %0d results outstanding", $time,
               frame_results_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Update the tracked frame state with one accepted item and queue the
  // frame result when the last byte of a frame goes in.
  task automatic track_frame_byte(input sfcp_pkg::in_item_t it);
    logic [3:0]          pos;
    sfcp_pkg::out_item_t res;
    pos = it.frame_start ? sfcp_pkg::PosFirst : trk_pos;
    if (pos == sfcp_pkg::PosIdle) return;
    if (pos == sfcp_pkg::PosFirst) begin
      trk_sum    = '0;
      trk_dist   = '0;
      trk_low_ok = 1'b0;
      trk_hdr_ok = (it.rx_byte == sfcp_pkg::Hdr0Byte);
    end else if (pos == sfcp_pkg::PosHdr1) begin
      trk_hdr_ok = trk_hdr_ok && (it.rx_byte == sfcp_pkg::Hdr1Byte);
    end
    if (pos < sfcp_pkg::PosSumLow) trk_sum = trk_sum + 16'(it.rx_byte);
    if (pos >= sfcp_pkg::PosDistLo && pos <= sfcp_pkg::PosDistHi) begin
      trk_dist[(pos - sfcp_pkg::PosDistLo) * 8 +: 8] = it.rx_byte;
    end
    if (pos == sfcp_pkg::PosSumLow) trk_low_ok = (trk_sum[7:0] == it.rx_byte);
    if (pos == sfcp_pkg::PosLast) begin
      if (!trk_hdr_ok) begin
        res.frame_status = sfcp_pkg::StatusBadHeader;
      end else if (!(trk_low_ok && trk_sum[15:8] == it.rx_byte)) begin
        res.frame_status = sfcp_pkg::StatusBadSum;
      end else begin
        res.frame_status = sfcp_pkg::StatusOk;
        last_good_dist   = trk_dist;
      end
      res.distance = last_good_dist;
      frame_results_due.push_back(res);
      trk_pos = sfcp_pkg::PosIdle;
    end else begin
      trk_pos = pos + 4'd1;
    end
  endtask

  // Result side: random back-pressure and a field-by-field compare.
  always @(posedge clk_i) begin
    sfcp_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      case (out_data_o.frame_status)
        sfcp_pkg::StatusOk:        n_ok++;
        sfcp_pkg::StatusBadHeader: n_bad_hdr++;
        default:                   n_bad_sum++;
      endcase
      if (frame_results_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with no frame pending, status %0d distance %08h", $time,
                 out_data_o.frame_status, out_data_o.distance);
      end else begin
        want = frame_results_due.pop_front();
        if (out_data_o.frame_status !== want.frame_status) begin
          mismatches++;
          $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                   want.frame_status, out_data_o.frame_status);
        end
        if (out_data_o.distance !== want.distance) begin
          mismatches++;
          $display("%0t: distance mismatch, expected %08h, actual %08h", $time,
                   want.distance, out_data_o.distance);
        end
      end
    end
    out_stall_i <= !no_idle && ($urandom_range(99) < 16);
  end

  // Offer one item, with random idle cycles first, and hold it until taken.
  task automatic push_byte(input sfcp_pkg::in_item_t it);
    while (!no_idle && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    track_frame_byte(it);
  endtask

  task automatic push_loose_byte(input logic [7:0] b, input bit start);
    sfcp_pkg::in_item_t it;
    it.rx_byte     = b;
    it.frame_start = start;
    push_byte(it);
  endtask

  // Sends the first len bytes of a frame, the first one flagged as start.
  task automatic send_frame(input frame_bytes_t f, input int unsigned len);
    sfcp_pkg::in_item_t it;
    for (int unsigned k = 0; k < len; k++) begin
      it.rx_byte     = f[k];
      it.frame_start = (k == 0);
      push_byte(it);
      frame_bytes++;
    end
  endtask

  // Builds a complete frame with a correct checksum, then breaks the
  // header, the checksum or both as the kind asks.
  function automatic frame_bytes_t make_frame(input frame_kind_e kind,
                                              input logic [31:0] frame_dist,
                                              input bit rand_body,
                                              input logic [7:0] body);
    frame_bytes_t f;
    logic [15:0]  s;
    for (int k = 0; k < FrameLen; k++) begin
      f[k] = rand_body ? 8'($urandom_range(255)) : body;
    end
    f[sfcp_pkg::PosFirst] = sfcp_pkg::Hdr0Byte;
    f[sfcp_pkg::PosHdr1]  = sfcp_pkg::Hdr1Byte;
    if (kind == KindBadHdr0 || kind == KindBadBoth) begin
      do f[sfcp_pkg::PosFirst] = 8'($urandom_range(255));
      while (f[sfcp_pkg::PosFirst] == sfcp_pkg::Hdr0Byte);
    end
    if (kind == KindBadHdr1) begin
      do f[sfcp_pkg::PosHdr1] = 8'($urandom_range(255));
      while (f[sfcp_pkg::PosHdr1] == sfcp_pkg::Hdr1Byte);
    end
    for (int k = 0; k < 4; k++) f[sfcp_pkg::PosDistLo + k] = frame_dist[8 * k +: 8];
    s = '0;
    for (int k = 0; k < sfcp_pkg::PosSumLow; k++) s = s + 16'(f[k]);
    f[sfcp_pkg::PosSumLow] = s[7:0];
    f[sfcp_pkg::PosLast]   = s[15:8];
    if (kind == KindBadSumLow || kind == KindBadBoth) begin
      f[sfcp_pkg::PosSumLow] = f[sfcp_pkg::PosSumLow] ^ 8'($urandom_range(1, 255));
    end
    if (kind == KindBadSumHigh) begin
      f[sfcp_pkg::PosLast] = f[sfcp_pkg::PosLast] ^ 8'($urandom_range(1, 255));
    end
    return f;
  endfunction

  function automatic frame_kind_e pick_kind();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 62) return KindGood;
    if (r < 70) return KindBadHdr0;
    if (r < 76) return KindBadHdr1;
    if (r < 84) return KindBadSumLow;
    if (r < 92) return KindBadSumHigh;
    return KindBadBoth;
  endfunction

  function automatic logic [31:0] pick_distance();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Stops offering items until every queued frame result has come out.
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (frame_results_due.size() != 0);
  endtask

  // Each status, the byte extremes, idle bytes, restarts and trailing bytes.
  task automatic test_frame_cases();
    // A failing frame straight after reset reports the zero kept distance.
    send_frame(make_frame(KindBadHdr0, 32'h0bad_0bad, 1'b1, 8'h00), FrameLen);
    send_frame(make_frame(KindGood, 32'h1234_5678, 1'b1, 8'h00), FrameLen);
    send_frame(make_frame(KindGood, 32'hffff_ffff, 1'b0, 8'hff), FrameLen);
    send_frame(make_frame(KindGood, 32'h0000_0000, 1'b0, 8'h00), FrameLen);
    send_frame(make_frame(KindGood, 32'ha5c3_0f81, 1'b1, 8'h00), FrameLen);
    send_frame(make_frame(KindBadHdr1, 32'h5555_aaaa, 1'b1, 8'h00), FrameLen);
    send_frame(make_frame(KindBadSumLow, 32'h0102_0304, 1'b1, 8'h00), FrameLen);
    send_frame(make_frame(KindBadSumHigh, 32'h0506_0708, 1'b1, 8'h00), FrameLen);
    send_frame(make_frame(KindBadBoth, 32'h090a_0b0c, 1'b1, 8'h00), FrameLen);
    // Bytes without a start flag while idle are dropped.
    push_loose_byte(8'h00, 1'b0);
    push_loose_byte(8'hff, 1'b0);
    push_loose_byte(sfcp_pkg::Hdr0Byte, 1'b0);
    // A new start abandons a partial frame, also one byte short of the end.
    send_frame(make_frame(KindGood, 32'hdead_beef, 1'b1, 8'h00), 7);
    send_frame(make_frame(KindGood, 32'h7f00_0080, 1'b1, 8'h00), 14);
    send_frame(make_frame(KindGood, 32'h8000_0001, 1'b1, 8'h00), FrameLen);
    // Bytes after the last one of a frame are dropped too.
    push_loose_byte(sfcp_pkg::Hdr0Byte, 1'b0);
    push_loose_byte(sfcp_pkg::Hdr1Byte, 1'b0);
  endtask

  // Mostly whole frames with random content, some cut short, some noise.
  task automatic test_random_traffic(input int unsigned byte_target);
    int unsigned r;
    while (frame_bytes < byte_target) begin
      r = $urandom_range(99);
      if (r < 6) begin
        repeat ($urandom_range(1, 3)) push_loose_byte(8'($urandom_range(255)), 1'b0);
      end else if (r < 16) begin
        send_frame(make_frame(pick_kind(), pick_distance(), 1'b1, 8'h00),
                   $urandom_range(1, FrameLen - 1));
      end else begin
        send_frame(make_frame(pick_kind(), pick_distance(), 1'b1, 8'h00), FrameLen);
      end
    end
  endtask

  // Frames at full rate with the result side never stalled.
  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (24) send_frame(make_frame(pick_kind(), pick_distance(), 1'b1, 8'h00), FrameLen);
    no_idle = 1'b0;
  endtask

  // Each frame waits until the previous result has been taken.
  task automatic test_pause_until_drained();
    repeat (6) begin
      send_frame(make_frame(pick_kind(), pick_distance(), 1'b1, 8'h00), FrameLen);
      wait_results_drained();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_frame_cases();
    test_random_traffic(700);
    test_back_to_back();
    test_pause_until_drained();
    test_random_traffic(1450);
    wait_results_drained();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d frame bytes in whole, short and noisy frames with random gaps.",
             frame_bytes);
    $display("Checked results: %0d ok, %0d bad header, %0d bad checksum.",
             n_ok, n_bad_hdr, n_bad_sum);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
